>>> hdl/skf_pkg.sv
// Shared types and constants of the scalar Kalman filter.
package skf_pkg;

  // Gain is unsigned Q0.16; the value one needs a seventeenth bit.
  localparam int GAIN_BITS = 16;
  localparam int GAIN_W    = 17;
  localparam logic [GAIN_W-1:0] GAIN_ONE = 17'h10000;

  // Restoring divider produces one quotient bit per step.
  localparam int DIV_STEPS = GAIN_W;
  localparam int DIV_CNT_W = 5;

  // Configuration register indexes.
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_PROCESS_NOISE      = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MEASUREMENT_NOISE  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_INITIAL_ESTIMATE   = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_INITIAL_COVARIANCE = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture the sample, reload state on restart
    logic prep;      // predicted covariance p + q
    logic div_init;  // denominator check, divider and residual setup
    logic div_step;  // one quotient bit
    logic mul;       // both products
    logic upd;       // write back estimate and covariance
    logic out_load;  // move the result into the output register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic den_zero;  // p + q + r is zero
    logic out_busy;  // output register holds a result not yet taken
  } dp_status_t;

endpackage

>>> hdl/scalar_kalman_filter.sv
// Top level of the scalar Kalman filter: ports, configuration registers, units.
//
//   Channel  Direction  Carries
//   s_*      in         measurement (tdata), restart (tuser)
//   m_*      out        estimate, gain, covariance (tdata), error (tuser)
//   cfg_*    in         register writes, index 0..3
//
// A result passes the states prep, divider setup, the 17-step restoring divider
// for the gain, multiply, update and output; a zero p + q + r skips to output.
// One item is in work at a time; the next is taken once its result sits in the
// output register, so a stalled output holds off the input only while a second
// result is ready. Reset is synchronous and loads the register defaults and
// the initial estimate and covariance.
module scalar_kalman_filter #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // Input stream.
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  input  logic [((DATA_WIDTH+7)/8)*8-1:0]        s_tdata,  // measurement
  input  logic                                   s_tuser,  // restart
  // Output stream.
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // estimate, gain, covariance
  output logic [((2*DATA_WIDTH+16+7)/8)*8-1:0]   m_tdata,
  output logic                                   m_tuser,  // error
  // Configuration write port.
  input  logic                                   cfg_we,
  input  logic [skf_pkg::CFG_INDEX_W-1:0]        cfg_index,
  input  logic [DATA_WIDTH-1:0]                  cfg_data
);

  localparam int DW = DATA_WIDTH;
  localparam int CW = DATA_WIDTH - 1;
  localparam int GW = skf_pkg::GAIN_W;
  localparam logic [CW-1:0] Q_RESET  = CW'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);
  localparam logic [CW-1:0] R_RESET  = CW'(64'd2 << FRAC_BITS);
  localparam logic [CW-1:0] P0_RESET = CW'(64'd2 << FRAC_BITS);

  logic [CW-1:0]        process_noise;
  logic [CW-1:0]        measurement_noise;
  logic signed [DW-1:0] initial_estimate;
  logic [CW-1:0]        initial_covariance;

  skf_pkg::dp_cmd_t     cmd;
  skf_pkg::dp_status_t  status;

  logic signed [DW-1:0] out_estimate;
  logic [GW-1:0]        out_gain;
  logic [CW-1:0]        out_covariance;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      process_noise      <= Q_RESET;
      measurement_noise  <= R_RESET;
      initial_estimate   <= '0;
      initial_covariance <= P0_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        skf_pkg::REG_PROCESS_NOISE:      process_noise      <= cfg_data[CW-1:0];
        skf_pkg::REG_MEASUREMENT_NOISE:  measurement_noise  <= cfg_data[CW-1:0];
        skf_pkg::REG_INITIAL_ESTIMATE:   initial_estimate   <= cfg_data;
        skf_pkg::REG_INITIAL_COVARIANCE: initial_covariance <= cfg_data[CW-1:0];
        default: begin
        end
      endcase
    end
  end

  skf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .cmd      (cmd),
    .status   (status)
  );

  skf_dp #(
    .DATA_WIDTH (DATA_WIDTH),
    .COV_RESET  (P0_RESET)
  ) u_dp (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .status             (status),
    .process_noise      (process_noise),
    .measurement_noise  (measurement_noise),
    .initial_estimate   (initial_estimate),
    .initial_covariance (initial_covariance),
    .measurement        (s_tdata[DW-1:0]),
    .restart            (s_tuser),
    .out_ready          (m_tready),
    .out_valid          (m_tvalid),
    .out_estimate       (out_estimate),
    .out_gain           (out_gain),
    .out_covariance     (out_covariance),
    .out_error          (m_tuser)
  );

  // Result packing, first field in the lowest bits.
  always_comb begin
    m_tdata                 = '0;
    m_tdata[DW-1:0]         = out_estimate;
    m_tdata[DW +: GW]       = out_gain;
    m_tdata[DW + GW +: CW]  = out_covariance;
  end

endmodule

>>> hdl/skf_ctrl.sv
// Sequencing state machine of the scalar Kalman filter.
module skf_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output skf_pkg::dp_cmd_t    cmd,
  input  skf_pkg::dp_status_t status
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_DINIT,
    S_DIV,
    S_MUL,
    S_UPD,
    S_OUT
  } state_t;

  state_t                          state;
  logic [skf_pkg::DIV_CNT_W-1:0]   cnt;

  // State register and divider step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) state <= S_PREP;
        end
        S_PREP: begin
          state <= S_DINIT;
        end
        S_DINIT: begin
          cnt <= '0;
          // A zero denominator skips the update entirely.
          if (status.den_zero) state <= S_OUT;
          else state <= S_DIV;
        end
        S_DIV: begin
          cnt <= cnt + 1'b1;
          if (cnt == skf_pkg::DIV_CNT_W'(skf_pkg::DIV_STEPS - 1)) state <= S_MUL;
        end
        S_MUL: begin
          state <= S_UPD;
        end
        S_UPD: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (!status.out_busy) state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Command decode.
  always_comb begin
    in_ready     = (state == S_IDLE);
    cmd          = '0;
    cmd.load     = (state == S_IDLE) && in_valid;
    cmd.prep     = (state == S_PREP);
    cmd.div_init = (state == S_DINIT);
    cmd.div_step = (state == S_DIV);
    cmd.mul      = (state == S_MUL);
    cmd.upd      = (state == S_UPD);
    cmd.out_load = (state == S_OUT) && !status.out_busy;
  end

endmodule

>>> hdl/skf_dp.sv
// Arithmetic datapath of the scalar Kalman filter: state, divider, multipliers.
module skf_dp #(
  parameter int DATA_WIDTH = 32,
  parameter logic [DATA_WIDTH-2:0] COV_RESET = '0
) (
  input  logic                              clk,
  input  logic                              rst,
  input  skf_pkg::dp_cmd_t                  cmd,
  output skf_pkg::dp_status_t               status,
  input  logic [DATA_WIDTH-2:0]             process_noise,
  input  logic [DATA_WIDTH-2:0]             measurement_noise,
  input  logic signed [DATA_WIDTH-1:0]      initial_estimate,
  input  logic [DATA_WIDTH-2:0]             initial_covariance,
  input  logic signed [DATA_WIDTH-1:0]      measurement,
  input  logic                              restart,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic signed [DATA_WIDTH-1:0]      out_estimate,
  output logic [skf_pkg::GAIN_W-1:0]        out_gain,
  output logic [DATA_WIDTH-2:0]             out_covariance,
  output logic                              out_error
);

  localparam int DW  = DATA_WIDTH;
  localparam int CW  = DATA_WIDTH - 1;
  localparam int GW  = skf_pkg::GAIN_W;
  localparam int RW  = DATA_WIDTH + 1;
  localparam int PEW = RW + GW;
  localparam int PCW = CW + GW;
  localparam int XW  = PEW - skf_pkg::GAIN_BITS;

  logic signed [DW-1:0]  meas_r;
  logic signed [DW-1:0]  est_r;
  logic [CW-1:0]         cov_r;
  logic [CW-1:0]         p1_r;
  logic [DW-1:0]         den_r;
  logic [DW:0]           rem_r;
  logic [GW-1:0]         quo_r;
  logic signed [RW-1:0]  res_r;
  logic                  err_r;
  logic signed [PEW-1:0] prod_e_r;
  logic [PCW-1:0]        prod_c_r;

  logic [DW-1:0]         p1_sum;
  logic [CW-1:0]         p1_sat;
  logic [DW-1:0]         den_sum;
  logic                  ge;
  logic [DW:0]           rem_sub;
  logic signed [RW-1:0]  res;
  logic signed [GW:0]    gain_s;
  logic signed [PEW-1:0] res_ext;
  logic signed [PEW-1:0] gain_ext;
  logic [GW-1:0]         gain_comp;
  logic signed [XW-1:0]  delta;
  logic signed [XW-1:0]  x_sum;
  logic                  sat_hi;
  logic                  sat_lo;
  logic signed [DW-1:0]  est_next;

  // Predicted covariance saturates at the largest covariance value.
  always_comb begin
    p1_sum  = {1'b0, cov_r} + {1'b0, process_noise};
    p1_sat  = p1_sum[CW] ? '1 : p1_sum[CW-1:0];
    den_sum = {1'b0, p1_r} + {1'b0, measurement_noise};
  end

  // One restoring division step; the remainder stays below the divisor.
  always_comb begin
    ge      = (rem_r >= {1'b0, den_r});
    rem_sub = ge ? (rem_r - {1'b0, den_r}) : rem_r;
  end

  // Residual and multiplier operands.
  always_comb begin
    res       = $signed({meas_r[DW-1], meas_r}) - $signed({est_r[DW-1], est_r});
    gain_s    = $signed({1'b0, quo_r});
    res_ext   = PEW'(res_r);
    gain_ext  = PEW'(gain_s);
    gain_comp = skf_pkg::GAIN_ONE - quo_r;
  end

  // Estimate update with floor scaling and saturation to the signed range.
  always_comb begin
    delta    = prod_e_r[PEW-1:skf_pkg::GAIN_BITS];
    x_sum    = delta + XW'(est_r);
    sat_hi   = !x_sum[XW-1] && (x_sum[XW-2:DW-1] != '0);
    sat_lo   = x_sum[XW-1] && (x_sum[XW-2:DW-1] != '1);
    if (sat_hi) begin
      est_next = {1'b0, {(DW-1){1'b1}}};
    end else if (sat_lo) begin
      est_next = {1'b1, {(DW-1){1'b0}}};
    end else begin
      est_next = x_sum[DW-1:0];
    end
  end

  // Filter state: estimate and covariance.
  always_ff @(posedge clk) begin
    if (rst) begin
      est_r <= '0;
      cov_r <= COV_RESET;
    end else if (cmd.load) begin
      if (restart) begin
        est_r <= initial_estimate;
        cov_r <= initial_covariance;
      end
    end else if (cmd.upd) begin
      est_r <= est_next;
      cov_r <= prod_c_r[skf_pkg::GAIN_BITS +: CW];
    end
  end

  // Working registers of one step.
  always_ff @(posedge clk) begin
    if (cmd.load) meas_r <= measurement;
    if (cmd.prep) p1_r <= p1_sat;
    if (cmd.div_init) begin
      den_r <= den_sum;
      rem_r <= {2'b00, p1_r};
      quo_r <= '0;
      res_r <= res;
      err_r <= (den_sum == '0);
    end
    if (cmd.div_step) begin
      rem_r <= {rem_sub[DW-1:0], 1'b0};
      quo_r <= {quo_r[GW-2:0], ge};
    end
    if (cmd.mul) begin
      prod_e_r <= res_ext * gain_ext;
      prod_c_r <= PCW'(p1_r) * PCW'(gain_comp);
    end
  end

  // Output register; it holds a result until the consumer takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_estimate   <= est_r;
      out_gain       <= quo_r;
      out_covariance <= cov_r;
      out_error      <= err_r;
    end
  end

  always_comb begin
    status.den_zero = (den_sum == '0);
    status.out_busy = out_valid && !out_ready;
  end

endmodule

>>> hdl/skf_checker.sv
// Port-level checks of the scalar Kalman filter, bound to the top level.
module skf_checker #(
  parameter int DATA_WIDTH = 32
) (
  input logic                                   clk,
  input logic                                   rst,
  input logic                                   s_tvalid,
  input logic                                   s_tready,
  input logic                                   m_tvalid,
  input logic                                   m_tready,
  input logic [((2*DATA_WIDTH+16+7)/8)*8-1:0]   m_tdata,
  input logic                                   m_tuser
);

  localparam int GW = skf_pkg::GAIN_W;
  localparam int CW = DATA_WIDTH - 1;

  logic [GW-1:0] gain;
  logic [CW-1:0] cov;

  assign gain = m_tdata[DATA_WIDTH +: GW];
  assign cov  = m_tdata[DATA_WIDTH + GW +: CW];

  // A stalled result stays offered.
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  // One item at a time: no transaction right after one was taken.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while an item is in work");

  // A skipped update reports zero gain.
  a_err_gain: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> gain == '0)
    else $error("nonzero gain with error flag");

  // Full gain collapses the covariance.
  a_full_gain: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (gain == skf_pkg::GAIN_ONE) |-> cov == '0)
    else $error("covariance not zero at full gain");

endmodule

bind scalar_kalman_filter skf_checker #(.DATA_WIDTH(DATA_WIDTH)) u_skf_checker (.*);
